// ===== hdl/cgo_pkg.sv =====
package cgo_pkg;

  localparam int unsigned GroupW    = 6;
  localparam int unsigned ColW      = 31;
  localparam int unsigned StartW    = 32;
  localparam int unsigned CountW    = 31;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 31;
  localparam int unsigned MaxGroupsDef = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_COLS  = 2'd0,
    CFG_COL_BLOCK  = 2'd1,
    CFG_COL_REM    = 2'd2,
    CFG_INDEX_BASE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [GroupW-1:0] grid_cols;
    logic [ColW-1:0]   col_block;
    logic [GroupW-1:0] col_rem;
    logic              index_base;
  } cfg_t;

  // one result beat, offset in the low bits
  typedef struct packed {
    logic              is_total;
    logic [GroupW-1:0] group;
    logic [CountW-1:0] offset;
  } result_t;

  typedef struct packed {
    logic cap;         // capture the input beat
    logic emit_grp;    // stage start of pending group, step to next group
    logic calc;        // work out first column of pending group
    logic row_done;    // rewind to group zero
    logic emit_total;  // stage the total count, clear the counter
    logic flush;       // send staged result as last of the item
    logic nnz_inc;     // count the nonzero
  } dp_cmd_t;

  typedef struct packed {
    logic hit;         // pending group starts at this item
    logic op_end;
    logic last_row;
    logic can_push;    // staging slot may move on this cycle
  } dp_sts_t;

endpackage

// ===== hdl/cgo_ctrl.sv =====
module cgo_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cgo_pkg::dp_sts_t sts_i,
  output cgo_pkg::dp_cmd_t cmd_o
);
  import cgo_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_CALC  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.can_push) begin
          if (sts_i.hit) begin
            cmd_o.emit_grp = 1'b1;
            state_d        = ST_CALC;
          end else if (sts_i.op_end && sts_i.last_row) begin
            cmd_o.row_done   = 1'b1;
            cmd_o.emit_total = 1'b1;
            state_d          = ST_FLUSH;
          end else begin
            cmd_o.flush    = 1'b1;
            cmd_o.row_done = sts_i.op_end;
            cmd_o.nnz_inc  = !sts_i.op_end;
            state_d        = ST_IDLE;
          end
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_FLUSH: begin
        if (sts_i.can_push) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/cgo_dpath.sv =====
module cgo_dpath #(
  parameter int unsigned MaxGroups = cgo_pkg::MaxGroupsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cgo_pkg::cfg_t             cfg_i,
  input  cgo_pkg::dp_cmd_t          cmd_i,
  output cgo_pkg::dp_sts_t          sts_o,
  input  logic                      in_op_i,
  input  logic [cgo_pkg::ColW-1:0]  in_col_i,
  input  logic                      in_last_row_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output cgo_pkg::result_t          out_res_o,
  output logic                      out_last_o
);
  import cgo_pkg::*;

  localparam logic [GroupW-1:0] MaxG = GroupW'(MaxGroups);
  localparam logic [CountW-1:0] CntMax = '1;

  // captured item
  logic              op_q, last_row_q;
  logic [ColW-1:0]   col_q;

  // walk state
  logic [CountW-1:0] nnz_q, nnz_d;
  logic [GroupW-1:0] pg_q, pg_d;
  logic [StartW-1:0] start_q, start_d;

  // staging slot and output register
  logic              cand_v_q, cand_v_d;
  result_t           cand_q, cand_d;
  logic              out_vld_q, out_vld_d;
  result_t           out_q, out_d;
  logic              out_last_q, out_last_d;

  logic [GroupW-1:0] grp_cnt;
  logic              col_neg;
  logic [ColW-1:0]   col_adj;
  logic              out_free;
  logic              push;

  logic [ColW+GroupW-1:0] prod;
  logic [GroupW-1:0]      extra;
  logic [ColW+GroupW:0]   sum;
  logic [StartW-1:0]      next_start;

  always_comb begin
    if (cfg_i.grid_cols == '0) begin
      grp_cnt = GroupW'(1);
    end else if (cfg_i.grid_cols > MaxG) begin
      grp_cnt = MaxG;
    end else begin
      grp_cnt = cfg_i.grid_cols;
    end
  end

  // col 0 with base 1 lies before every group start
  assign col_neg = cfg_i.index_base && (col_q == '0);
  assign col_adj = col_q - ColW'(cfg_i.index_base);

  assign sts_o.hit = (pg_q < grp_cnt) &&
                     (op_q || (pg_q == '0) ||
                      (!col_neg && ({1'b0, col_adj} >= start_q)));
  assign sts_o.op_end   = op_q;
  assign sts_o.last_row = last_row_q;
  assign out_free       = !out_vld_q || out_ready_i;
  assign sts_o.can_push = !cand_v_q || out_free;

  // group start = g * col_block + min(g, col_rem), saturating at 32 bits
  assign prod  = (ColW+GroupW)'(pg_q) * (ColW+GroupW)'(cfg_i.col_block);
  assign extra = (pg_q < cfg_i.col_rem) ? pg_q : cfg_i.col_rem;
  assign sum   = {1'b0, prod} + (ColW+GroupW+1)'(extra);
  assign next_start = (|sum[ColW+GroupW:StartW]) ? '1 : sum[StartW-1:0];

  assign push = cmd_i.emit_grp | cmd_i.emit_total | cmd_i.flush;

  always_comb begin
    nnz_d      = nnz_q;
    pg_d       = pg_q;
    start_d    = start_q;
    cand_v_d   = cand_v_q;
    cand_d     = cand_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    out_last_d = out_last_q;

    if (push && cand_v_q) begin
      out_vld_d  = 1'b1;
      out_d      = cand_q;
      out_last_d = cmd_i.flush;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end

    if (cmd_i.emit_grp) begin
      cand_v_d        = 1'b1;
      cand_d.offset   = nnz_q;
      cand_d.group    = pg_q;
      cand_d.is_total = 1'b0;
      pg_d            = pg_q + GroupW'(1);
    end
    if (cmd_i.calc) begin
      start_d = next_start;
    end
    if (cmd_i.row_done) begin
      pg_d    = '0;
      start_d = '0;
    end
    if (cmd_i.emit_total) begin
      cand_v_d        = 1'b1;
      cand_d.offset   = nnz_q;
      cand_d.group    = '0;
      cand_d.is_total = 1'b1;
      nnz_d           = '0;
    end
    if (cmd_i.flush) begin
      cand_v_d = 1'b0;
    end
    if (cmd_i.nnz_inc && (nnz_q != CntMax)) begin
      nnz_d = nnz_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nnz_q     <= '0;
      pg_q      <= '0;
      start_q   <= '0;
      cand_v_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      nnz_q     <= nnz_d;
      pg_q      <= pg_d;
      start_q   <= start_d;
      cand_v_q  <= cand_v_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q       <= in_op_i;
      col_q      <= in_col_i;
      last_row_q <= in_last_row_i;
    end
    cand_q     <= cand_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hdl/csr_column_group_offsets.sv =====
// Operation: an input beat is taken, then a decide step follows; each group start it
//   emits adds a decide step and a step that multiplies out the next group's column.
// A last row adds a flush step for the total; decide and flush wait while the staging
//   slot cannot move on. One item in flight: no new beat is taken until it is done.
// Reset (rst_ni low, async): registers to defaults, counters and group walk
//   cleared, no beat held on either side.
module csr_column_group_offsets #(
  parameter int unsigned MaxGroups = cgo_pkg::MaxGroupsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write port
  input  logic                         cfg_we_i,
  input  logic [cgo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cgo_pkg::CfgDataW-1:0] cfg_wdata_i,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [31:0]                  s_axis_tdata_i,  // [30:0] col, [31] pad
  input  logic                         s_axis_tuser_i,  // [0] op (1 = row end)
  input  logic                         s_axis_tlast_i,  // last_row
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [39:0]                  m_axis_tdata_o,  // [30:0] offset,
                                                        // [36:31] group, [39:37] pad
  output logic                         m_axis_tuser_o,  // [0] is_total
  output logic                         m_axis_tlast_o   // last beat of the item
);
  import cgo_pkg::*;

  cfg_t    cfg_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  result_t res;

  // Configuration registers; write them only between items (the block does not enforce it).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_cols  <= GroupW'(1);
      cfg_q.col_block  <= '0;
      cfg_q.col_rem    <= '0;
      cfg_q.index_base <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_COLS:  cfg_q.grid_cols  <= cfg_wdata_i[GroupW-1:0];
        CFG_COL_BLOCK:  cfg_q.col_block  <= cfg_wdata_i[ColW-1:0];
        CFG_COL_REM:    cfg_q.col_rem    <= cfg_wdata_i[GroupW-1:0];
        CFG_INDEX_BASE: cfg_q.index_base <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer: accept, decide per pending group, stage, flush.
  cgo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Counters, group walk, start multiplier, staging slot and output register.
  // The staging slot holds one result back until it is known whether another
  // follows, so tlast can be set on the right beat.
  cgo_dpath #(
    .MaxGroups (MaxGroups)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_op_i       (s_axis_tuser_i),
    .in_col_i      (s_axis_tdata_i[ColW-1:0]),
    .in_last_row_i (s_axis_tlast_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_res_o     (res),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, res.group, res.offset};
  assign m_axis_tuser_o = res.is_total;

  // Total beat always carries group zero.
  a_total_group0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[36:31] == '0))
    else $error("total beat with nonzero group");

  // Group starts stay within the group limit.
  a_group_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      (m_axis_tdata_o[36:31] < GroupW'(MaxGroups)))
    else $error("group beyond limit");

  // A total beat always ends its item.
  a_total_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("total beat without tlast");

  // One item at a time: after a take, no new take in the next cycle.
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while an item is in flight");

endmodule

// ===== bench/csr_column_group_offsets_check.sv =====
module csr_column_group_offsets_check #(
  parameter int unsigned MaxGroups = cgo_pkg::MaxGroupsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cgo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cgo_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_i,
  input  logic [31:0]                  s_axis_tdata_i,   // [30:0] col, [31] pad
  input  logic                         s_axis_tuser_i,   // [0] op
  input  logic                         s_axis_tlast_i,   // last_row
  input  logic                         m_axis_tvalid_i,
  input  logic                         m_axis_tready_i,
  input  logic [39:0]                  m_axis_tdata_i,   // [30:0] offset, [36:31] group,
                                                         // [39:37] pad
  input  logic                         m_axis_tuser_i,   // [0] is_total
  input  logic                         m_axis_tlast_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  beats_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cgo_pkg::*;

  typedef struct packed {
    logic [CountW-1:0] offset;
    logic [GroupW-1:0] group;
    logic              is_total;
    logic              last;
  } offset_beat_t;

  offset_beat_t      offsets_due[$];
  cfg_t              regs;
  logic [CountW-1:0] nnz_seen;
  logic [GroupW-1:0] open_grp;
  logic [StartW-1:0] open_grp_col;
  int unsigned       mismatches;
  int unsigned       checked;

  function automatic int unsigned live_groups();
    int unsigned g;
    g = regs.grid_cols;
    if (g == 0) g = 1;
    if (g > MaxGroups) g = MaxGroups;
    return g;
  endfunction

  // first column of group g, clamped to 32 bits
  function automatic logic [StartW-1:0] group_first_col(input logic [GroupW-1:0] g);
    longint extra;
    longint v;
    extra = (g < regs.col_rem) ? longint'(g) : longint'(regs.col_rem);
    v = longint'(g) * longint'(regs.col_block) + extra;
    if (v > longint'(32'hFFFF_FFFF)) v = longint'(32'hFFFF_FFFF);
    return StartW'(v);
  endfunction

  function automatic void open_group(input logic total);
    offset_beat_t b;
    b.offset   = nnz_seen;
    b.group    = total ? '0 : open_grp;
    b.is_total = total;
    b.last     = 1'b0;
    offsets_due.push_back(b);
    if (!total) begin
      open_grp     = open_grp + 1'b1;
      open_grp_col = group_first_col(open_grp);
    end
  endfunction

  function automatic void predict_offsets(input logic row_end, input logic [ColW-1:0] col,
                                          input logic last_row);
    int unsigned groups;
    int unsigned held;
    longint      c;
    groups = live_groups();
    held   = offsets_due.size();
    if (!row_end) begin
      c = longint'(col) - longint'(regs.index_base);
      while (open_grp < groups && (open_grp == 0 || c >= longint'(open_grp_col)))
        open_group(1'b0);
      if (nnz_seen != '1) nnz_seen = nnz_seen + 1'b1;
    end else begin
      while (open_grp < groups) open_group(1'b0);
      open_grp     = '0;
      open_grp_col = '0;
      if (last_row) begin
        open_group(1'b1);
        nnz_seen = '0;
      end
    end
    if (offsets_due.size() > held) offsets_due[offsets_due.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    offset_beat_t want;
    offset_beat_t got;
    if (!rst_ni) begin
      regs.grid_cols   = 6'd1;
      regs.col_block   = '0;
      regs.col_rem     = '0;
      regs.index_base  = 1'b0;
      nnz_seen         = '0;
      open_grp         = '0;
      open_grp_col     = '0;
      mismatches       = 0;
      checked          = 0;
      offsets_due.delete();
      fail_count_o    <= 0;
      pending_o       <= 0;
      beats_o         <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.offset   = m_axis_tdata_i[CountW-1:0];
        got.group    = m_axis_tdata_i[CountW +: GroupW];
        got.is_total = m_axis_tuser_i;
        got.last     = m_axis_tlast_i;
        checked++;
        if (offsets_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result beat: offset %0d group %0d total %0b last %0b",
                     $realtime, got.offset, got.group, got.is_total, got.last);
        end else begin
          want = offsets_due.pop_front();
          if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result beat mismatch: want offset %0d group %0d total %0b ",
                        "last %0b, got offset %0d group %0d total %0b last %0b"},
                       $realtime, want.offset, want.group, want.is_total, want.last,
                       got.offset, got.group, got.is_total, got.last);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_offsets(s_axis_tuser_i, s_axis_tdata_i[ColW-1:0], s_axis_tlast_i);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_GRID_COLS:  regs.grid_cols  = cfg_wdata_i[GroupW-1:0];
          CFG_COL_BLOCK:  regs.col_block  = cfg_wdata_i[ColW-1:0];
          CFG_COL_REM:    regs.col_rem    = cfg_wdata_i[GroupW-1:0];
          CFG_INDEX_BASE: regs.index_base = cfg_wdata_i[0];
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= offsets_due.size();
      beats_o      <= checked;
    end
  end

endmodule

// ===== bench/csr_column_group_offsets_test.sv =====
// Stimulus and verdict for the CSR column-group offset block. Prediction and
// comparison live in the checker beside the DUT; this module only feeds beats,
// writes the registers between matrices and stalls the result side.
module csr_column_group_offsets_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cgo_pkg::*;

  localparam int unsigned MaxGroups = MaxGroupsDef;

  // input beat kinds, carried on tuser
  localparam logic OpNonzero = 1'b0;
  localparam logic OpRowEnd  = 1'b1;

  localparam logic [ColW-1:0] ColMax = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [31:0]         s_tdata;   // [30:0] col, [31] pad
  logic                s_tuser;   // [0] op
  logic                s_tlast;   // last_row
  logic                m_tvalid;
  logic                m_tready;
  logic [39:0]         m_tdata;   // [30:0] offset, [36:31] group, [39:37] pad
  logic                m_tuser;   // [0] is_total
  logic                m_tlast;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned beats_checked;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned beats_sent;
  int unsigned matrices;
  int unsigned settings;

  csr_column_group_offsets #(
    .MaxGroups (MaxGroups)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  csr_column_group_offsets_check #(
    .MaxGroups (MaxGroups)
  ) u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .fail_count_o    (fail_cnt),
    .pending_o       (pending),
    .beats_o         (beats_checked)
  );

  always #4 clk_i = ~clk_i;

  // result side back-pressure, redrawn every cycle
  always @(posedge clk_i) m_tready <= ($urandom_range(99) >= sink_stall_pct);

  // hard stop, well clear of the slowest legal run (17 results per beat, long stalls)
  initial begin
    #4ms;
    $display("csr_column_group_offsets regression: fail");
    $finish;
  end

  // One beat on the input side. valid stays high between back-to-back beats and
  // is only dropped when an idle gap is drawn.
  task automatic put_beat(input logic op, input logic [ColW-1:0] col, input logic last_row);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, col};
    s_tuser  <= op;
    s_tlast  <= last_row;
    do @(posedge clk_i); while (!s_tready);
    beats_sent++;
  endtask

  // Hold the input off until every predicted offset has come back, then allow
  // for a trailing beat that emits nothing, with margin.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [GroupW-1:0] gc, input logic [ColW-1:0] cb,
                           input logic [GroupW-1:0] cr, input logic base);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_GRID_COLS;
    cfg_wdata <= CfgDataW'(gc);
    @(posedge clk_i);
    cfg_idx   <= CFG_COL_BLOCK;
    cfg_wdata <= CfgDataW'(cb);
    @(posedge clk_i);
    cfg_idx   <= CFG_COL_REM;
    cfg_wdata <= CfgDataW'(cr);
    @(posedge clk_i);
    cfg_idx   <= CFG_INDEX_BASE;
    cfg_wdata <= CfgDataW'(base);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // One random matrix: grid derived from a random width (now and then an
  // unrelated block/remainder pair), a few rows of sorted columns, a sprinkle
  // of out-of-order and below-base columns.
  task automatic run_matrix(input bit wide);
    logic [GroupW-1:0] gc;
    logic [ColW-1:0]   cb;
    logic [GroupW-1:0] cr;
    logic              base;
    logic [ColW-1:0]   col;
    longint unsigned   width;
    longint unsigned   c;
    longint unsigned   stride;
    int unsigned       rows;
    int unsigned       k;
    int unsigned       pick;
    drain();
    pick = $urandom_range(9);
    if (pick == 0)      gc = '0;
    else if (pick == 1) gc = '1;
    else if (pick == 2) gc = GroupW'(MaxGroups);
    else                gc = GroupW'($urandom_range(20, 1));
    width = wide ? $urandom_range(32'h7FFF_FFFE, 1) : $urandom_range(300, 1);
    if (gc == 0) begin
      cb = ColW'(width);
      cr = '0;
    end else begin
      cb = ColW'(width / gc);
      cr = GroupW'(width % gc);
    end
    if ($urandom_range(7) == 0) begin
      cb = ColW'($urandom());
      cr = GroupW'($urandom_range(62));
    end
    base = 1'($urandom_range(1));
    write_cfg(gc, cb, cr, base);
    rows = $urandom_range(4, 1);
    for (int unsigned r = 0; r < rows; r++) begin
      k = ($urandom_range(9) == 0) ? 0 : $urandom_range(7, 1);
      stride = (k == 0) ? 1 : width / k + 1;
      c = 0;
      for (int unsigned i = 0; i < k; i++) begin
        c = c + $urandom_range(32'(stride));
        if (c >= width) c = width - 1;
        col = ColW'(c + base);
        if ($urandom_range(15) == 0) col = ColW'($urandom());
        if (base && i == 0 && $urandom_range(5) == 0) col = '0;
        put_beat(OpNonzero, col, 1'($urandom_range(1)));
      end
      put_beat(OpRowEnd, ColW'($urandom()),
               (r == rows - 1) ? ($urandom_range(7) != 0) : 1'b0);
    end
    matrices++;
  endtask

  initial begin
    int unsigned src_pct[4];
    int unsigned sink_pct[4];
    int unsigned phase_start;
    src_pct  = '{0, 56, 0, 17};
    sink_pct = '{0, 0, 56, 17};
    src_idle_pct   = 0;
    sink_stall_pct <= 0;
    beats_sent     = 0;
    matrices       = 0;
    settings       = 0;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_GRID_COLS;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OpNonzero;
    s_tlast   <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // -- directed: reset registers, one group
    put_beat(OpNonzero, 31'd5, 1'b0);
    put_beat(OpRowEnd, '0, 1'b1);

    // 42 columns over 4 groups: starts 0, 11, 22, 32
    drain();
    write_cfg(6'd4, 31'd10, 6'd2, 1'b0);
    put_beat(OpNonzero, 31'd0, 1'b0);
    put_beat(OpNonzero, 31'd11, 1'b1);    // last_row on a nonzero is ignored
    put_beat(OpNonzero, 31'd40, 1'b0);    // jumps over two group starts
    put_beat(OpRowEnd, ColMax, 1'b0);     // nothing left pending
    put_beat(OpRowEnd, '0, 1'b0);         // empty row: every group at row end
    put_beat(OpNonzero, 31'd21, 1'b0);
    put_beat(OpRowEnd, '0, 1'b1);

    // group count 0 acts as 1; column below base opens group zero
    drain();
    write_cfg('0, ColMax, 6'd62, 1'b1);
    put_beat(OpNonzero, 31'd0, 1'b0);
    put_beat(OpNonzero, 31'd0, 1'b0);
    put_beat(OpRowEnd, '0, 1'b1);

    // group count clamped, far starts saturate; empty last row gives the most results
    drain();
    write_cfg('1, ColMax, 6'd62, 1'b0);
    put_beat(OpNonzero, ColMax, 1'b0);
    put_beat(OpRowEnd, '0, 1'b0);
    put_beat(OpRowEnd, ColMax, 1'b1);

    // below-base column after the row has opened
    drain();
    write_cfg(6'd4, 31'd10, 6'd2, 1'b1);
    put_beat(OpNonzero, 31'd3, 1'b0);
    put_beat(OpNonzero, 31'd0, 1'b0);
    put_beat(OpNonzero, 31'd12, 1'b0);
    put_beat(OpRowEnd, '0, 1'b1);

    // -- random matrices across the four handshake phases
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct    = src_pct[ph];
      sink_stall_pct <= sink_pct[ph];
      phase_start     = beats_sent;
      while (beats_sent - phase_start < 90) run_matrix($urandom_range(3) == 0);
    end

    drain();
    repeat (16) @(posedge clk_i);

    $display("run covered %0d input beats in %0d random matrices, %0d register settings",
             beats_sent, matrices, settings);
    $display("%0d result beats checked, %0d still outstanding, %0d mismatches",
             beats_checked, pending, fail_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("csr_column_group_offsets regression: pass");
    end else begin
      $display("csr_column_group_offsets regression: fail");
    end
    $finish;
  end

endmodule

// ===== csr_column_group_offsets.f =====
hdl/cgo_pkg.sv
hdl/cgo_ctrl.sv
hdl/cgo_dpath.sv
hdl/csr_column_group_offsets.sv
bench/csr_column_group_offsets_check.sv
bench/csr_column_group_offsets_test.sv
